[hdl/bsff_pkg.sv]
`default_nettype none

package bsff_pkg;

  localparam int WORD_W      = 64;
  localparam int LOG_W       = 6;
  localparam int SIZE_W      = 13;
  localparam int IDX_W       = 12;
  localparam int WIDX_W      = 6;
  // word counts up to (2^SIZE_W + WORD_W - 1) / WORD_W
  localparam int CNT_W       = SIZE_W + 1 - LOG_W;
  localparam int MAP_BITS_DEF = 4096;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  typedef enum logic [3:0] {
    OP_SET         = 4'd0,
    OP_CLEAR       = 4'd1,
    OP_TEST        = 4'd2,
    OP_SET_ALL     = 4'd3,
    OP_CLEAR_ALL   = 4'd4,
    OP_FIRST_SET   = 4'd5,
    OP_FIRST_CLEAR = 4'd6,
    OP_LAST_SET    = 4'd7,
    OP_LAST_CLEAR  = 4'd8,
    OP_ALL_CLEAR   = 4'd9,
    OP_RANGE_CLEAR = 4'd10,
    OP_WORD_CLEAR  = 4'd11,
    OP_OR          = 4'd12,
    OP_AND         = 4'd13,
    OP_ANDNOT      = 4'd14,
    OP_EQUAL       = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_SCAN,
    ST_FINISH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;    // latch request fields
    logic setup;   // load word pointer and count
    logic fill;    // write one word of set all / clear all
    logic scan;    // read / evaluate words
    logic finish;  // form result
  } ctl_cmd_t;

  typedef struct packed {
    logic err;       // request rejected
    logic empty;     // no words to visit
    logic is_fill;   // set all / clear all
    logic last;      // one word left
    logic hit;       // scan can stop now
    logic scan_end;  // all reads issued and evaluated
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/bsff_ctrl.sv]
`default_nettype none

module bsff_ctrl
  import bsff_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  output logic            done,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        priority if (status.err || status.empty) state_next = ST_FINISH;
        else if (status.is_fill)                 state_next = ST_FILL;
        else                                     state_next = ST_SCAN;
      end
      ST_FILL: begin
        if (status.last) state_next = ST_FINISH;
      end
      ST_SCAN: begin
        if (status.hit || status.scan_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && start;
    cmd.setup  = (state == ST_SETUP);
    cmd.fill   = (state == ST_FILL);
    cmd.scan   = (state == ST_SCAN);
    cmd.finish = (state == ST_FINISH);
    busy       = (state != ST_IDLE);
    done       = (state == ST_RESULT);
  end

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SETUP))
    else $error("accepted request did not enter setup");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe longer than one cycle");

  a_finish_to_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> done)
    else $error("result not presented after finish");

endmodule

`default_nettype wire

[hdl/bsff_dp.sv]
`default_nettype none

module bsff_dp
  import bsff_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               size_in_use_we,
  input  wire logic [SIZE_W-1:0]  size_in_use,
  input  wire logic [3:0]         operation,
  input  wire logic [IDX_W-1:0]   bit_index,
  input  wire logic [SIZE_W-1:0]  range_end,
  input  wire logic [WIDX_W-1:0]  word_index,
  input  wire logic [WORD_W-1:0]  word_value,
  input  wire ctl_cmd_t           cmd,
  output dp_status_t              status,
  output logic                    flag,
  output logic [SIZE_W-1:0]       found_index,
  output logic                    index_error
);

  localparam int NUM_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  // in-use bits of word w for map size sz
  function automatic logic [WORD_W-1:0] word_mask(input logic [CNT_W-1:0] w,
                                                  input logic [SIZE_W-1:0] sz_i);
    logic [SIZE_W:0] base;
    logic [SIZE_W:0] n;
    base = {w, LOG_W'(0)};
    n    = {1'b0, sz_i} - base;
    if (base >= {1'b0, sz_i}) return '0;
    if (n >= (SIZE_W+1)'(WORD_W)) return '1;
    return ~({WORD_W{1'b1}} << n[LOG_W-1:0]);
  endfunction

  function automatic logic [LOG_W-1:0] low_pos(input logic [WORD_W-1:0] m);
    logic [LOG_W-1:0] p;
    p = LOG_W'(WORD_W - 1);
    for (int i = WORD_W - 1; i >= 0; i--)
      if (m[i]) p = LOG_W'(i);
    return p;
  endfunction

  function automatic logic [LOG_W-1:0] high_pos(input logic [WORD_W-1:0] m);
    logic [LOG_W-1:0] p;
    p = '0;
    for (int i = 0; i < WORD_W; i++)
      if (m[i]) p = LOG_W'(i);
    return p;
  endfunction

  logic [SIZE_W-1:0] size_reg;
  op_t               op_q;
  logic [IDX_W-1:0]  bi_q;
  logic [SIZE_W-1:0] re_q;
  logic [WIDX_W-1:0] wi_q;
  logic [WORD_W-1:0] wv_q;

  logic [SIZE_W-1:0] sz;
  logic [SIZE_W:0]   sz_up;
  logic [CNT_W-1:0]  nel;

  logic              err_d, fill_d, rev;
  logic [CNT_W-1:0]  first_d, count_d;
  logic [SIZE_W-1:0] range_diff;

  logic [CNT_W-1:0]  ptr, remaining, rd_addr_q, hit_w_q;
  logic              rd_pending, rd_en;
  logic              err_q, hit_q, flag_q;
  logic [WORD_W-1:0] hit_m_q;

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_ok;
  logic [WORD_W-1:0] rd_raw;
  logic              rd_vb;

  logic              eval_act, eval_we, write_op, hit_d, flag_d, clear_srch;
  logic [WORD_W-1:0] data, mask_r, bit_sel, new_word, srch_m, fill_word;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [LOG_W-1:0]  pos;
  logic [SIZE_W:0]   found_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
    end else if (size_in_use_we) begin
      size_reg <= size_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= op_t'(operation);
      bi_q <= bit_index;
      re_q <= range_end;
      wi_q <= word_index;
      wv_q <= word_value;
    end
  end

  assign sz    = (32'(size_reg) > MAP_BITS) ? SIZE_W'(MAP_BITS) : size_reg;
  assign sz_up = {1'b0, sz} + (SIZE_W+1)'(WORD_W - 1);
  assign nel   = sz_up[SIZE_W:LOG_W];
  assign rev   = (op_q == OP_LAST_SET) || (op_q == OP_LAST_CLEAR);
  assign range_diff = re_q - SIZE_W'(bi_q);

  // word span and error check of the latched request
  always_comb begin
    err_d   = 1'b0;
    fill_d  = 1'b0;
    first_d = '0;
    count_d = nel;
    unique case (op_q)
      OP_SET, OP_CLEAR, OP_TEST: begin
        err_d   = ({1'b0, bi_q} >= sz);
        first_d = CNT_W'(bi_q[IDX_W-1:LOG_W]);
        count_d = CNT_W'(1);
      end
      OP_SET_ALL, OP_CLEAR_ALL: begin
        fill_d = 1'b1;
      end
      OP_FIRST_SET, OP_FIRST_CLEAR, OP_ALL_CLEAR: begin
        first_d = '0;
      end
      OP_LAST_SET, OP_LAST_CLEAR: begin
        first_d = nel - CNT_W'(1);
      end
      OP_RANGE_CLEAR: begin
        err_d   = ({1'b0, bi_q} > re_q) || (re_q > sz) ||
                  (bi_q[LOG_W-1:0] != '0) || (re_q[LOG_W-1:0] != '0);
        first_d = CNT_W'(bi_q[IDX_W-1:LOG_W]);
        count_d = CNT_W'(range_diff[SIZE_W-1:LOG_W]);
      end
      OP_WORD_CLEAR, OP_OR, OP_AND, OP_ANDNOT, OP_EQUAL: begin
        err_d   = (CNT_W'(wi_q) >= nel);
        first_d = CNT_W'(wi_q);
        count_d = CNT_W'(1);
      end
    endcase
  end

  assign rd_en = cmd.scan && (remaining != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      remaining  <= '0;
      rd_pending <= 1'b0;
      err_q      <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      if (cmd.setup) begin
        ptr       <= first_d;
        remaining <= err_d ? '0 : count_d;
        err_q     <= err_d;
        hit_q     <= 1'b0;
      end else if (cmd.fill) begin
        ptr       <= ptr + CNT_W'(1);
        remaining <= remaining - CNT_W'(1);
      end else if (rd_en) begin
        ptr       <= rev ? ptr - CNT_W'(1) : ptr + CNT_W'(1);
        remaining <= remaining - CNT_W'(1);
      end
      if (eval_act && hit_d) hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_addr_q <= ptr;
    if (cmd.setup) begin
      flag_q <= 1'b0;
    end else if (eval_act) begin
      flag_q <= flag_d;
    end
    if (eval_act && hit_d) begin
      hit_m_q <= srch_m;
      hit_w_q <= rd_addr_q;
    end
  end

  // word store; a word never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      word_ok <= '0;
    end else if (mem_we) begin
      word_ok[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_raw <= mem[AW'(ptr)];
      rd_vb  <= word_ok[AW'(ptr)];
    end
  end

  assign eval_act   = cmd.scan && rd_pending;
  assign data       = rd_vb ? rd_raw : '0;
  assign mask_r     = word_mask(rd_addr_q, sz);
  assign bit_sel    = WORD_W'(1) << bi_q[LOG_W-1:0];
  assign clear_srch = (op_q == OP_FIRST_CLEAR) || (op_q == OP_LAST_CLEAR);
  assign srch_m     = (clear_srch ? ~data : data) & mask_r;

  always_comb begin
    new_word = data;
    write_op = 1'b0;
    hit_d    = 1'b0;
    flag_d   = 1'b0;
    unique case (op_q)
      OP_SET: begin
        new_word = data | bit_sel;
        write_op = 1'b1;
      end
      OP_CLEAR: begin
        new_word = data & ~bit_sel;
        write_op = 1'b1;
      end
      OP_TEST:       flag_d = data[bi_q[LOG_W-1:0]];
      OP_SET_ALL, OP_CLEAR_ALL: begin
        write_op = 1'b0;
      end
      OP_FIRST_SET, OP_FIRST_CLEAR, OP_LAST_SET, OP_LAST_CLEAR: begin
        hit_d = (srch_m != '0);
      end
      OP_ALL_CLEAR, OP_RANGE_CLEAR: begin
        hit_d = (data != '0);
      end
      OP_WORD_CLEAR: flag_d = (data == '0);
      OP_OR: begin
        // bits above the size stay clear in the last word
        new_word = data | (wv_q & mask_r);
        write_op = 1'b1;
      end
      OP_AND: begin
        new_word = data & wv_q;
        write_op = 1'b1;
      end
      OP_ANDNOT: begin
        new_word = data & ~wv_q;
        write_op = 1'b1;
      end
      OP_EQUAL:      flag_d = (data == wv_q);
    endcase
  end

  assign eval_we   = eval_act && write_op;
  assign fill_word = (op_q == OP_SET_ALL) ? word_mask(ptr, sz) : '0;
  assign mem_we    = cmd.fill || eval_we;
  assign wr_addr   = cmd.fill ? AW'(ptr) : AW'(rd_addr_q);
  assign wr_data   = cmd.fill ? fill_word : new_word;

  always_comb begin
    status          = '0;
    status.err      = err_d;
    status.empty    = (count_d == '0);
    status.is_fill  = fill_d;
    status.last     = (remaining == CNT_W'(1));
    status.hit      = eval_act && hit_d;
    status.scan_end = (remaining == '0) && !rd_pending;
  end

  assign pos        = rev ? high_pos(hit_m_q) : low_pos(hit_m_q);
  assign found_full = {hit_w_q, pos};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      flag        <= 1'b0;
      found_index <= '0;
      index_error <= err_q;
      if (!err_q) begin
        unique case (op_q)
          OP_TEST, OP_WORD_CLEAR, OP_EQUAL: flag <= flag_q;
          OP_ALL_CLEAR, OP_RANGE_CLEAR:     flag <= !hit_q;
          OP_FIRST_SET, OP_FIRST_CLEAR, OP_LAST_SET, OP_LAST_CLEAR: begin
            found_index <= hit_q ? found_full[SIZE_W-1:0] : sz;
          end
          OP_SET, OP_CLEAR, OP_SET_ALL, OP_CLEAR_ALL,
          OP_OR, OP_AND, OP_ANDNOT: flag <= 1'b0;
        endcase
      end
    end
  end

  a_ptr_in_use: assert property (@(posedge clk) disable iff (rst)
    (cmd.fill || rd_en) |-> (ptr < nel))
    else $error("word access outside the in-use words");

  a_reject_no_write: assert property (@(posedge clk) disable iff (rst)
    eval_we |-> !err_q)
    else $error("rejected request modified the map");

  a_one_write_src: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fill && eval_act))
    else $error("fill and read-modify-write overlap");

endmodule

`default_nettype wire

[hdl/bitmap_store_find_first.sv]
`default_nettype none
// Bit map store with set/clear/test, whole-map fill, find first/last set or
// clear, all-clear checks and whole-word OR/AND/AND-NOT/compare.
// Request channel: operation, bit_index, range_end, word_index and
// word_value are taken at a clock edge where start is high and busy is low.
// One request is worked on at a time; busy stays high until the result.
// Result channel: flag, found_index and index_error are valid for exactly
// one cycle while done is high; there is no backpressure.
// From accept to done a request passes setup, then fill (words written) or
// scan (words read, then evaluated), then finish and result; a request that
// is rejected or spans no words goes from setup straight to finish.
// Fills and searches move one word a cycle through the store's write and
// read ports. size_in_use is to be written by the user with size_in_use_we
// only while the block is idle; the block itself does not enforce this.
// Reset clears the map to all zero at once (per-word valid bits) and sets
// size_in_use to 4096; a request can be accepted the cycle after reset.

module bitmap_store_find_first
  import bsff_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               size_in_use_we,
  input  wire logic [SIZE_W-1:0]  size_in_use,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         operation,
  input  wire logic [IDX_W-1:0]   bit_index,
  input  wire logic [SIZE_W-1:0]  range_end,
  input  wire logic [WIDX_W-1:0]  word_index,
  input  wire logic [WORD_W-1:0]  word_value,
  output logic                    done,
  output logic                    flag,
  output logic [SIZE_W-1:0]       found_index,
  output logic                    index_error
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  bsff_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  bsff_dp #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .size_in_use_we (size_in_use_we),
    .size_in_use    (size_in_use),
    .operation      (operation),
    .bit_index      (bit_index),
    .range_end      (range_end),
    .word_index     (word_index),
    .word_value     (word_value),
    .cmd            (cmd),
    .status         (status),
    .flag           (flag),
    .found_index    (found_index),
    .index_error    (index_error)
  );

endmodule

`default_nettype wire
